// ----- hw/rtl/bsi_pkg.sv -----
// Shared types, constants and helpers for the boid steer and integrate block.
// No dependencies; imported by boid_steer_and_integrate, bsi_checker and tb.
package bsi_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int CSR_IDX_W = 2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SPEED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FORCE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP = 2'd2;

   localparam logic [30:0] MAX_SPEED_RST = 31'd6553600;
   localparam logic [30:0] MAX_FORCE_RST = 31'd327680;
   localparam logic [16:0] TIME_STEP_RST = 17'd1092;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_STEER = 2'd1,
      OP_FORCE = 2'd2,
      OP_LOAD  = 2'd3
   } op_type;

   // magnitude of a signed 32-bit value (the most negative value maps to 2^31)
   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      logic [31:0] r;
      r = v[31] ? 32'(-v) : 32'(v);
      return r;
   endfunction

   // clamp a wide signed sum to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sh0_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sh0_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [65:0] sx66(input logic signed [31:0] v);
      return 66'(v);
   endfunction

endpackage

// ----- hw/rtl/boid_steer_and_integrate.sv -----
// Boid seek steering and integration in signed fixed point, one boid.
// Depends on bsi_pkg.
//
// Usage:
//  - req channel (req_valid / req_stall): one operation per transfer, tick,
//    steer toward a target, apply force or load state. req_stall is low only
//    while the sequencer is idle; a transfer is taken when valid and not stall.
//  - rsp channel (rsp_valid / rsp_stall): exactly one transfer per request,
//    position and velocity after the operation.
//  - csr channel (csr_valid / csr_ready): register writes, always ready.
//    Write only while no request is in flight.
// Load and apply force go straight to completion; a tick runs one normalize
// and a steer up to two; a short vector ends a steer early.
// A normalize forms the squared length (ST_N_SQX to ST_N_CHK), a 32-step square
// root and two divisions of 2 setup plus 31 steps, on one shared 32x32
// multiplier and 64-bit compare/subtract steps. A new request is accepted only
// once the sequencer is back in idle after the previous one.
// Reset clears position, velocity, acceleration and restores the register
// defaults. While rsp is stalled the result is held and a new request is
// accepted and worked on; it finishes only once the held result is taken.
module boid_steer_and_integrate #(
   parameter int FRAC_BITS = bsi_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_operation,
   input  logic signed [31:0]             req_vec_x,
   input  logic signed [31:0]             req_vec_y,
   input  logic signed [31:0]             req_load_vel_x,
   input  logic signed [31:0]             req_load_vel_y,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_pos_out_x,
   output logic signed [31:0]             rsp_pos_out_y,
   output logic signed [31:0]             rsp_vel_out_x,
   output logic signed [31:0]             rsp_vel_out_y,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bsi_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]                    csr_wdata
);
   import bsi_pkg::*;

   // squared length below this counts as too short: ceil(1e-8 * 2^(2F))
   localparam longint unsigned LEN2_MIN =
      ((64'd1 << (2 * FRAC_BITS)) + 64'd99999999) / 64'd100000000;

   typedef enum logic [4:0] {
      ST_IDLE, ST_TK_MX, ST_TK_AX, ST_TK_MY, ST_TK_AY, ST_TK_W,
      ST_TK_PMX, ST_TK_PX, ST_TK_PMY, ST_TK_PY,
      ST_ST_D, ST_ST_F, ST_ST_ACC,
      ST_N_SQX, ST_N_SQY, ST_N_SUM, ST_N_CHK, ST_N_SQRT,
      ST_N_MUL, ST_N_LDV, ST_N_DIV, ST_DONE
   } state_type;

   // which caller a normalize returns to
   typedef enum logic [1:0] {
      CTX_TICK, CTX_SEEK, CTX_FORCE
   } ctx_type;

   state_type          state_ff, state_in;
   ctx_type            ctx_ff, ctx_in;
   logic               comp_ff, comp_in;
   logic [4:0]         cnt_ff, cnt_in;
   logic [30:0]        max_speed_ff, max_speed_in;
   logic [30:0]        max_force_ff, max_force_in;
   logic [16:0]        time_step_ff, time_step_in;
   logic signed [31:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [31:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [31:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;
   logic signed [31:0] wx_ff, wx_in, wy_ff, wy_in;
   logic signed [31:0] tgt_x_ff, tgt_x_in, tgt_y_ff, tgt_y_in;
   logic [63:0]        prod_ff, prod_in;
   logic [63:0]        sq_ff, sq_in;
   logic [63:0]        n_ff, n_in, r_ff, r_in, b_ff, b_in;
   logic [63:0]        rem_ff, rem_in, dvs_ff, dvs_in;
   logic [30:0]        q_ff, q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_px_ff, rsp_px_in, rsp_py_ff, rsp_py_in;
   logic signed [31:0] rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        dt_mag;
   logic signed [65:0] dt_val;
   logic signed [31:0] dt_ref;
   logic [63:0]        sq_trial;
   logic               sq_take;
   logic               div_take;
   logic [30:0]        q_nx;
   logic signed [31:0] w_sel;
   logic signed [31:0] div_res;
   logic [30:0]        scale;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_out_x = rsp_px_ff;
   assign rsp_pos_out_y = rsp_py_ff;
   assign rsp_vel_out_x = rsp_vx_ff;
   assign rsp_vel_out_y = rsp_vy_ff;

   assign scale = (ctx_ff == CTX_FORCE) ? max_force_ff : max_speed_ff;

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_TK_MX:  begin mul_a = mag32(acc_x_ff); mul_b = 32'(time_step_ff); end
         ST_TK_MY:  begin mul_a = mag32(acc_y_ff); mul_b = 32'(time_step_ff); end
         ST_TK_PMX: begin mul_a = mag32(vel_x_ff); mul_b = 32'(time_step_ff); end
         ST_TK_PMY: begin mul_a = mag32(vel_y_ff); mul_b = 32'(time_step_ff); end
         ST_N_SQX:  begin mul_a = mag32(wx_ff); mul_b = mag32(wx_ff); end
         ST_N_SQY:  begin mul_a = mag32(wy_ff); mul_b = mag32(wy_ff); end
         ST_N_MUL:  begin
            mul_a = 32'(scale);
            mul_b = comp_ff ? mag32(wy_ff) : mag32(wx_ff);
         end
         default:   begin mul_a = '0; mul_b = '0; end
      endcase
   end

   // product times time step, sign restored from the scaled operand
   always_comb begin
      unique case (state_ff)
         ST_TK_AX: dt_ref = acc_x_ff;
         ST_TK_AY: dt_ref = acc_y_ff;
         ST_TK_PX: dt_ref = vel_x_ff;
         default:  dt_ref = vel_y_ff;
      endcase
      dt_mag = prod_ff >> FRAC_BITS;
      dt_val = dt_ref[31] ? -$signed({2'b00, dt_mag}) : $signed({2'b00, dt_mag});
   end

   // one square-root digit and one quotient bit per cycle
   assign sq_trial = r_ff + b_ff;
   assign sq_take  = (n_ff >= sq_trial);
   assign div_take = (rem_ff >= dvs_ff);
   assign q_nx     = {q_ff[29:0], div_take};
   assign w_sel    = comp_ff ? wy_ff : wx_ff;
   assign div_res  = w_sel[31] ? -$signed({1'b0, q_nx}) : $signed({1'b0, q_nx});

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      ctx_in = ctx_ff;
      comp_in = comp_ff;
      cnt_in = cnt_ff;
      max_speed_in = max_speed_ff;
      max_force_in = max_force_ff;
      time_step_in = time_step_ff;
      pos_x_in = pos_x_ff;
      pos_y_in = pos_y_ff;
      vel_x_in = vel_x_ff;
      vel_y_in = vel_y_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      wx_in = wx_ff;
      wy_in = wy_ff;
      tgt_x_in = tgt_x_ff;
      tgt_y_in = tgt_y_ff;
      prod_in = 64'(mul_a) * 64'(mul_b);
      sq_in = sq_ff;
      n_in = n_ff;
      r_in = r_ff;
      b_in = b_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      q_in = q_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_px_in = rsp_px_ff;
      rsp_py_in = rsp_py_ff;
      rsp_vx_in = rsp_vx_ff;
      rsp_vy_in = rsp_vy_ff;

      // register writes
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAX_SPEED: max_speed_in = csr_wdata[30:0];
            CSR_MAX_FORCE: max_force_in = csr_wdata[30:0];
            CSR_TIME_STEP: time_step_in = csr_wdata[16:0];
            default:       ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (op_type'(req_operation))
                  OP_TICK:  state_in = ST_TK_MX;
                  OP_STEER: begin
                     tgt_x_in = req_vec_x;
                     tgt_y_in = req_vec_y;
                     state_in = ST_ST_D;
                  end
                  OP_FORCE: begin
                     acc_x_in = sat32(sx66(acc_x_ff) + sx66(req_vec_x));
                     acc_y_in = sat32(sx66(acc_y_ff) + sx66(req_vec_y));
                     state_in = ST_DONE;
                  end
                  default: begin
                     pos_x_in = req_vec_x;
                     pos_y_in = req_vec_y;
                     vel_x_in = req_load_vel_x;
                     vel_y_in = req_load_vel_y;
                     acc_x_in = '0;
                     acc_y_in = '0;
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         // tick: velocity += accel * dt
         ST_TK_MX: state_in = ST_TK_AX;
         ST_TK_AX: begin
            vel_x_in = sat32(sx66(vel_x_ff) + dt_val);
            state_in = ST_TK_MY;
         end
         ST_TK_MY: state_in = ST_TK_AY;
         ST_TK_AY: begin
            vel_y_in = sat32(sx66(vel_y_ff) + dt_val);
            state_in = ST_TK_W;
         end
         ST_TK_W: begin
            wx_in = vel_x_ff;
            wy_in = vel_y_ff;
            ctx_in = CTX_TICK;
            comp_in = 1'b0;
            state_in = ST_N_SQX;
         end
         // tick: position += velocity * dt, then clear accel
         ST_TK_PMX: state_in = ST_TK_PX;
         ST_TK_PX: begin
            pos_x_in = sat32(sx66(pos_x_ff) + dt_val);
            state_in = ST_TK_PMY;
         end
         ST_TK_PMY: state_in = ST_TK_PY;
         ST_TK_PY: begin
            pos_y_in = sat32(sx66(pos_y_ff) + dt_val);
            acc_x_in = '0;
            acc_y_in = '0;
            state_in = ST_DONE;
         end
         // steer: offset to target, then desired minus velocity
         ST_ST_D: begin
            wx_in = sat32(sx66(tgt_x_ff) - sx66(pos_x_ff));
            wy_in = sat32(sx66(tgt_y_ff) - sx66(pos_y_ff));
            ctx_in = CTX_SEEK;
            comp_in = 1'b0;
            state_in = ST_N_SQX;
         end
         ST_ST_F: begin
            wx_in = sat32(sx66(wx_ff) - sx66(vel_x_ff));
            wy_in = sat32(sx66(wy_ff) - sx66(vel_y_ff));
            ctx_in = CTX_FORCE;
            comp_in = 1'b0;
            state_in = ST_N_SQX;
         end
         ST_ST_ACC: begin
            acc_x_in = sat32(sx66(acc_x_ff) + sx66(wx_ff));
            acc_y_in = sat32(sx66(acc_y_ff) + sx66(wy_ff));
            state_in = ST_DONE;
         end
         // normalize (wx, wy) to magnitude scale
         ST_N_SQX: state_in = ST_N_SQY;
         ST_N_SQY: begin
            sq_in = prod_ff;
            state_in = ST_N_SUM;
         end
         ST_N_SUM: begin
            sq_in = sq_ff + prod_ff;
            state_in = ST_N_CHK;
         end
         ST_N_CHK: begin
            if (sq_ff < LEN2_MIN) begin
               if (ctx_ff == CTX_TICK) begin
                  vel_x_in = '0;
                  vel_y_in = '0;
                  state_in = ST_TK_PMX;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               n_in = sq_ff;
               r_in = '0;
               b_in = 64'd1 << 62;
               cnt_in = 5'd31;
               state_in = ST_N_SQRT;
            end
         end
         ST_N_SQRT: begin
            if (sq_take) begin
               n_in = n_ff - sq_trial;
               r_in = (r_ff >> 1) + b_ff;
            end else begin
               r_in = r_ff >> 1;
            end
            b_in = b_ff >> 2;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_N_MUL;
            end
         end
         ST_N_MUL: state_in = ST_N_LDV;
         ST_N_LDV: begin
            rem_in = prod_ff;
            dvs_in = r_ff << 30;
            q_in = '0;
            cnt_in = 5'd30;
            state_in = ST_N_DIV;
         end
         ST_N_DIV: begin
            if (div_take) begin
               rem_in = rem_ff - dvs_ff;
            end
            dvs_in = dvs_ff >> 1;
            q_in = q_nx;
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               if (!comp_ff) begin
                  wx_in = div_res;
                  comp_in = 1'b1;
                  state_in = ST_N_MUL;
               end else begin
                  wy_in = div_res;
                  unique case (ctx_ff)
                     CTX_TICK: begin
                        vel_x_in = wx_ff;
                        vel_y_in = div_res;
                        state_in = ST_TK_PMX;
                     end
                     CTX_SEEK:  state_in = ST_ST_F;
                     default:   state_in = ST_ST_ACC;
                  endcase
               end
            end
         end
         // hand the result to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_px_in = pos_x_ff;
               rsp_py_in = pos_y_ff;
               rsp_vx_in = vel_x_ff;
               rsp_vy_in = vel_y_ff;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctx_ff <= CTX_TICK;
         comp_ff <= 1'b0;
         cnt_ff <= '0;
         max_speed_ff <= MAX_SPEED_RST;
         max_force_ff <= MAX_FORCE_RST;
         time_step_ff <= TIME_STEP_RST;
         pos_x_ff <= '0;
         pos_y_ff <= '0;
         vel_x_ff <= '0;
         vel_y_ff <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ctx_ff <= ctx_in;
         comp_ff <= comp_in;
         cnt_ff <= cnt_in;
         max_speed_ff <= max_speed_in;
         max_force_ff <= max_force_in;
         time_step_ff <= time_step_in;
         pos_x_ff <= pos_x_in;
         pos_y_ff <= pos_y_in;
         vel_x_ff <= vel_x_in;
         vel_y_ff <= vel_y_in;
         acc_x_ff <= acc_x_in;
         acc_y_ff <= acc_y_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      wx_ff <= wx_in;
      wy_ff <= wy_in;
      tgt_x_ff <= tgt_x_in;
      tgt_y_ff <= tgt_y_in;
      prod_ff <= prod_in;
      sq_ff <= sq_in;
      n_ff <= n_in;
      r_ff <= r_in;
      b_ff <= b_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      q_ff <= q_in;
      rsp_px_ff <= rsp_px_in;
      rsp_py_ff <= rsp_py_in;
      rsp_vx_ff <= rsp_vx_in;
      rsp_vy_ff <= rsp_vy_in;
   end

   // a request transfer always starts a busy period
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("sequencer took a request but stayed idle");

   // a new result appears only from the completion state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   // divider runs at most 31 quotient steps
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_N_DIV) |-> (cnt_ff <= 5'd30))
      else $error("divider step count out of range");

endmodule

// ----- bench/bsi_checker.sv -----
// Checker for boid_steer_and_integrate: watches the req, rsp and csr channels,
// predicts each result and compares it with the block's transfers.
// Depends on bsi_pkg for the operation codes and register indexes.
module bsi_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_operation,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_load_vel_x,
   input  logic signed [31:0] req_load_vel_y,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_pos_out_x,
   input  logic signed [31:0] rsp_pos_out_y,
   input  logic signed [31:0] rsp_vel_out_x,
   input  logic signed [31:0] rsp_vel_out_y,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 errors,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import bsi_pkg::*;

   localparam int FRAC = 16;
   // ceil(1e-8 * 2^32)
   localparam longint unsigned MIN_LEN2 = 43;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } boid_state_t;

   boid_state_t expected_states[$];

   // boid state and register copies
   longint p_x, p_y, v_x, v_y, a_x, a_y;
   longint unsigned spd_lim, frc_lim, dt;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint signed_as(longint r, longint unsigned m);
      return r < 0 ? -longint'(m) : longint'(m);
   endfunction

   function automatic longint scale_dt(longint a);
      return signed_as(a, (absval(a) * dt) >> FRAC);
   endfunction

   function automatic longint unsigned len_sq(longint x, longint y);
      return absval(x) * absval(x) + absval(y) * absval(y);
   endfunction

   // bitwise integer square root, floor
   function automatic longint unsigned int_root(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic rescale(inout longint x, inout longint y, input longint unsigned s,
                          input longint unsigned sq);
      longint unsigned len;
      len = int_root(sq);
      if (len == 0) len = 1;
      x = signed_as(x, (s * absval(x)) / len);
      y = signed_as(y, (s * absval(y)) / len);
   endtask

   task automatic predict(input op_type op, input longint vx, input longint vy,
                          input longint lx, input longint ly);
      longint dx, dy, fx, fy;
      longint unsigned sq;
      case (op)
         OP_TICK: begin
            v_x = clamp32(v_x + scale_dt(a_x));
            v_y = clamp32(v_y + scale_dt(a_y));
            sq = len_sq(v_x, v_y);
            if (sq >= MIN_LEN2) begin
               rescale(v_x, v_y, spd_lim, sq);
            end else begin
               // stopped boid
               v_x = 0;
               v_y = 0;
            end
            p_x = clamp32(p_x + scale_dt(v_x));
            p_y = clamp32(p_y + scale_dt(v_y));
            a_x = 0;
            a_y = 0;
         end
         OP_STEER: begin
            dx = clamp32(vx - p_x);
            dy = clamp32(vy - p_y);
            sq = len_sq(dx, dy);
            if (sq >= MIN_LEN2) begin
               rescale(dx, dy, spd_lim, sq);
               fx = clamp32(dx - v_x);
               fy = clamp32(dy - v_y);
               sq = len_sq(fx, fy);
               if (sq >= MIN_LEN2) begin
                  rescale(fx, fy, frc_lim, sq);
                  a_x = clamp32(a_x + fx);
                  a_y = clamp32(a_y + fy);
               end
            end
         end
         OP_FORCE: begin
            a_x = clamp32(a_x + vx);
            a_y = clamp32(a_y + vy);
         end
         default: begin
            p_x = vx;
            p_y = vy;
            v_x = lx;
            v_y = ly;
            a_x = 0;
            a_y = 0;
         end
      endcase
   endtask

   assign pending = expected_states.size();

   always @(posedge clock) begin
      boid_state_t want;
      if (reset) begin
         p_x = 0; p_y = 0; v_x = 0; v_y = 0; a_x = 0; a_y = 0;
         spd_lim = 64'(MAX_SPEED_RST);
         frc_lim = 64'(MAX_FORCE_RST);
         dt = 64'(TIME_STEP_RST);
         expected_states.delete();
         errors <= 0;
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_SPEED: spd_lim = 64'(csr_wdata[30:0]);
               CSR_MAX_FORCE: frc_lim = 64'(csr_wdata[30:0]);
               CSR_TIME_STEP: dt = 64'(csr_wdata[16:0]);
               default: ;
            endcase
         end
         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               $display("%0t: unexpected result pos=(%0d,%0d) vel=(%0d,%0d)", $time,
                        rsp_pos_out_x, rsp_pos_out_y, rsp_vel_out_x, rsp_vel_out_y);
               errors <= errors + 1;
            end else begin
               want = expected_states.pop_front();
               if (want.pos_x !== rsp_pos_out_x || want.pos_y !== rsp_pos_out_y ||
                   want.vel_x !== rsp_vel_out_x || want.vel_y !== rsp_vel_out_y) begin
                  $display("%0t: mismatch expected pos=(%0d,%0d) vel=(%0d,%0d)", $time,
                           want.pos_x, want.pos_y, want.vel_x, want.vel_y);
                  $display("%0t:          actual   pos=(%0d,%0d) vel=(%0d,%0d)", $time,
                           rsp_pos_out_x, rsp_pos_out_y, rsp_vel_out_x, rsp_vel_out_y);
                  errors <= errors + 1;
               end
            end
         end
         // request transfer
         if (req_valid && !req_stall) begin
            predict(op_type'(req_operation), longint'(req_vec_x), longint'(req_vec_y),
                    longint'(req_load_vel_x), longint'(req_load_vel_y));
            want.pos_x = p_x[31:0];
            want.pos_y = p_y[31:0];
            want.vel_x = v_x[31:0];
            want.vel_y = v_y[31:0];
            expected_states.push_back(want);
         end
      end
   end

endmodule

// ----- bench/tb.sv -----
// Top of the boid_steer_and_integrate testbench: clock, reset, stimulus,
// receiver stalls, watchdog and verdict. Depends on bsi_pkg and bsi_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import bsi_pkg::*;

   localparam int IDLE_LIMIT = 5000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_operation = '0;
   logic signed [31:0] req_vec_x = '0;
   logic signed [31:0] req_vec_y = '0;
   logic signed [31:0] req_load_vel_x = '0;
   logic signed [31:0] req_load_vel_y = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_pos_out_x, rsp_pos_out_y, rsp_vel_out_x, rsp_vel_out_y;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [1:0]         csr_index = '0;
   logic [31:0]        csr_wdata = '0;

   int errors;
   int pending;
   int idle_cycles = 0;
   int stall_left = 0;
   bit long_hold = 1'b0;
   bit no_stall = 1'b0;

   always #4 clock = ~clock;

   boid_steer_and_integrate u_dut (.*);

   bsi_checker u_chk (.*);

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver stalls in bursts: mostly short, a few long, one very long hold
   always @(posedge clock) begin
      int r;
      if (reset) begin
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
      end else if (long_hold) begin
         rsp_stall <= 1'b1;
         stall_left = 700;
         long_hold = 1'b0;
      end else if (no_stall) begin
         rsp_stall <= 1'b0;
      end else begin
         r = $urandom_range(0, 9);
         if (r < 5) begin
            rsp_stall <= 1'b0;
            stall_left = $urandom_range(0, 20);
         end else if (r < 9) begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(0, 3);
         end else begin
            rsp_stall <= 1'b1;
            stall_left = $urandom_range(20, 150);
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 80) : $urandom_range(0, 2);
      if (n != 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_op(op_type op, logic [31:0] x, logic [31:0] y,
                          logic [31:0] lx, logic [31:0] ly);
      idle_gap();
      req_valid <= 1'b1;
      req_operation <= op;
      req_vec_x <= x;
      req_vec_y <= y;
      req_load_vel_x <= lx;
      req_load_vel_y <= ly;
      do @(negedge clock); while (req_stall);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
   endtask

   // one write transfer, with a cycle of valid low before it
   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // mix of extremes, small signed values and full-range words
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 16)) - 8);
         3, 4: return $urandom;
         default: return 32'(int'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000);
      endcase
   endfunction

   // a run: load, then steers, forces and ticks, with an occasional random operation
   task automatic boid_run(int n);
      int r;
      send_op(OP_LOAD, pick_word(), pick_word(), pick_word(), pick_word());
      for (int i = 1; i < n; i++) begin
         r = $urandom_range(0, 9);
         if (r < 4) send_op(OP_STEER, pick_word(), pick_word(), $urandom, $urandom);
         else if (r < 6) send_op(OP_FORCE, pick_word(), pick_word(), $urandom, $urandom);
         else if (r < 9) send_op(OP_TICK, $urandom, $urandom, $urandom, $urandom);
         else send_op(op_type'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
                      $urandom);
      end
   endtask

   initial begin
      int sent;
      int run_len;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset defaults, extremes and the skip paths
      send_op(OP_TICK, 0, 0, 0, 0);                       // stopped boid
      send_op(OP_STEER, 0, 0, 0, 0);                      // short target offset
      send_op(OP_STEER, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_op(OP_TICK, 0, 0, 0, 0);
      send_op(OP_LOAD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_op(OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      send_op(OP_FORCE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);  // saturates
      send_op(OP_TICK, 0, 0, 0, 0);
      send_op(OP_STEER, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
      // velocity already equals desired: short steering force
      send_op(OP_LOAD, 0, 0, 32'd6553600, 0);
      send_op(OP_STEER, 32'h03E8_0000, 0, 0, 0);
      send_op(OP_LOAD, 32'h0001_0000, 32'hFFFF_0000, 32'd3, 32'hFFFF_FFFD);
      send_op(OP_TICK, 0, 0, 0, 0);                       // short velocity
      send_op(OP_STEER, 32'h0000_0004, 32'h0000_0003, 0, 0);
      send_op(OP_STEER, 32'h0050_0000, 32'hFFB0_0000, 0, 0);
      send_op(OP_TICK, 0, 0, 0, 0);
      send_op(OP_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();

      sent = 0;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_reg(CSR_MAX_SPEED, 32'hFFFF_FFFF);
               write_reg(CSR_MAX_FORCE, 32'h7FFF_FFFF);
               write_reg(CSR_TIME_STEP, 32'h0001_FFFF);
            end
            2: begin
               write_reg(CSR_MAX_SPEED, 0);
               write_reg(CSR_MAX_FORCE, 0);
               write_reg(CSR_TIME_STEP, 0);
            end
            3: begin
               write_reg(CSR_MAX_SPEED, 32'd6553600);
               write_reg(CSR_MAX_FORCE, 32'd327680);
               write_reg(CSR_TIME_STEP, 32'd65536);
               write_reg(CSR_TIME_STEP + 2'd1, $urandom);   // unknown index
            end
            default: begin
               write_reg(CSR_MAX_SPEED, $urandom);
               write_reg(CSR_MAX_FORCE, $urandom_range(0, 32'h00FF_FFFF) | (32'($urandom) << 31));
               write_reg(CSR_TIME_STEP, $urandom);
            end
         endcase
         if (phase == 4) long_hold = 1'b1;
         no_stall = (phase == 5);
         while (sent < (phase + 1) * 235) begin
            run_len = $urandom_range(4, 16);
            boid_run(run_len);
            sent = sent + run_len;
         end
         drain();
      end
      no_stall = 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (250) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
